### hdl/lri_pkg.sv
package lri_pkg;

  localparam int unsigned VAL_W      = 32;
  localparam int unsigned PROD_W     = 2 * VAL_W;
  localparam int unsigned DIV_CNT_W  = $clog2(PROD_W);
  localparam int unsigned IN_DATA_W  = 4 * VAL_W;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned CMD_W      = 2;

  localparam logic signed [VAL_W-1:0] ONE_Q16 = 32'sh0001_0000;
  localparam logic signed [VAL_W-1:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [VAL_W-1:0] S32_MIN = 32'sh8000_0000;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK       = 2'd0,
    CMD_SET        = 2'd1,
    CMD_RAMP_CUR   = 2'd2,
    CMD_RAMP_START = 2'd3
  } cmd_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic execute;
    logic mul;
    logic div_step;
    logic apply;
    logic load_out;
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic tick_go;
    logic div_last;
  } dp_status_t;

endpackage

### hdl/lri_datapath.sv
module lri_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lri_pkg::dp_cmd_t                    cmd_i,
  output lri_pkg::dp_status_t                 status_o,
  input  logic [lri_pkg::IN_DATA_W-1:0]       item_data_i,
  input  logic [lri_pkg::CMD_W-1:0]           item_cmd_i,
  output logic [lri_pkg::OUT_DATA_W-1:0]      out_data_o
);

  // architectural ramp state
  logic signed [lri_pkg::VAL_W-1:0] present_q, goal_q, origin_q;
  logic        [lri_pkg::VAL_W-1:0] period_q;
  logic                             finished_q, rising_q;

  // captured item
  lri_pkg::cmd_e                    item_cmd_q;
  logic signed [lri_pkg::VAL_W-1:0] sv_q, tv_q;
  logic        [lri_pkg::VAL_W-1:0] per_q, len_q;

  // tick work registers
  logic        [lri_pkg::VAL_W-1:0] absdiff_q, dist_q;
  logic signed [lri_pkg::VAL_W-1:0] bound_q;
  logic                             clamp_q, up_q;
  logic        [lri_pkg::PROD_W-1:0] dvd_q;
  logic        [lri_pkg::VAL_W-1:0] rem_q;
  logic        [lri_pkg::DIV_CNT_W-1:0] cnt_q;
  logic        [lri_pkg::OUT_DATA_W-1:0] out_q;

  logic                             period_nz, ahead;
  logic signed [lri_pkg::VAL_W:0]   diff_w, gap_w, room_w;
  logic                             diff_neg, up_w;
  logic        [lri_pkg::VAL_W-1:0] absdiff_w;
  logic signed [lri_pkg::VAL_W-1:0] ramp_origin;
  logic        [lri_pkg::VAL_W:0]   rem_sh, trial;
  logic                             qbit;
  logic        [lri_pkg::VAL_W:0]   msat;

  assign period_nz = |period_q;
  assign ahead     = rising_q ? (present_q < goal_q) : (goal_q < present_q);

  assign status_o.tick_go  = (item_cmd_q == lri_pkg::CMD_TICK) && !finished_q
                             && period_nz && ahead;
  assign status_o.div_last = &cnt_q;

  // direction and distance to the bound the move is limited by
  assign diff_w    = rising_q ? ({goal_q[31], goal_q} - {origin_q[31], origin_q})
                              : ({origin_q[31], origin_q} - {goal_q[31], goal_q});
  assign diff_neg  = diff_w[lri_pkg::VAL_W];
  assign absdiff_w = diff_neg ? lri_pkg::VAL_W'(-diff_w) : diff_w[lri_pkg::VAL_W-1:0];
  assign up_w      = rising_q ^ diff_neg;
  assign gap_w     = rising_q ? ({goal_q[31], goal_q} - {present_q[31], present_q})
                              : ({present_q[31], present_q} - {goal_q[31], goal_q});
  assign room_w    = up_w ? ({1'b0, lri_pkg::S32_MAX} - {present_q[31], present_q})
                          : ({present_q[31], present_q} - {1'b1, lri_pkg::S32_MIN});

  assign ramp_origin = (item_cmd_q == lri_pkg::CMD_RAMP_CUR) ? present_q : sv_q;

  // one restoring division step
  assign rem_sh = {rem_q, dvd_q[lri_pkg::PROD_W-1]};
  assign qbit   = rem_sh >= {1'b0, period_q};
  assign trial  = rem_sh - {1'b0, period_q};

  // quotient saturated to 33 bits for the final compare
  assign msat = (|dvd_q[lri_pkg::PROD_W-1:lri_pkg::VAL_W+1]) ? '1
                                                              : dvd_q[lri_pkg::VAL_W:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q  <= lri_pkg::ONE_Q16;
      goal_q     <= lri_pkg::ONE_Q16;
      origin_q   <= lri_pkg::ONE_Q16;
      period_q   <= '0;
      finished_q <= 1'b0;
      rising_q   <= 1'b1;
    end else if (cmd_i.execute) begin
      case (item_cmd_q) inside
        lri_pkg::CMD_TICK: begin
          if (!finished_q && !period_nz) begin
            present_q  <= goal_q;
            finished_q <= 1'b1;
          end
        end
        lri_pkg::CMD_SET: begin
          present_q <= sv_q;
          goal_q    <= sv_q;
          origin_q  <= sv_q;
        end
        lri_pkg::CMD_RAMP_CUR, lri_pkg::CMD_RAMP_START: begin
          goal_q   <= tv_q;
          origin_q <= ramp_origin;
          period_q <= per_q;
          if (per_q == '0) begin
            finished_q <= 1'b1;
            present_q  <= tv_q;
          end else if (tv_q == ramp_origin) begin
            finished_q <= 1'b1;
          end else begin
            finished_q <= 1'b0;
            rising_q   <= tv_q > ramp_origin;
          end
        end
        default: ;
      endcase
    end else if (cmd_i.apply) begin
      if (msat >= {1'b0, dist_q}) begin
        present_q <= bound_q;
        if (clamp_q) begin
          finished_q <= 1'b1;
        end
      end else if (up_q) begin
        present_q <= present_q + $signed(dvd_q[lri_pkg::VAL_W-1:0]);
      end else begin
        present_q <= present_q - $signed(dvd_q[lri_pkg::VAL_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.mul) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_cmd_q <= lri_pkg::cmd_e'(item_cmd_i);
      sv_q       <= item_data_i[31:0];
      tv_q       <= item_data_i[63:32];
      per_q      <= item_data_i[95:64];
      len_q      <= item_data_i[127:96];
    end
    if (cmd_i.execute) begin
      absdiff_q <= absdiff_w;
      up_q      <= up_w;
      clamp_q   <= !diff_neg;
      dist_q    <= diff_neg ? room_w[lri_pkg::VAL_W-1:0] : gap_w[lri_pkg::VAL_W-1:0];
      bound_q   <= !diff_neg ? goal_q : (up_w ? lri_pkg::S32_MAX : lri_pkg::S32_MIN);
    end
    if (cmd_i.mul) begin
      dvd_q <= lri_pkg::PROD_W'(absdiff_q) * lri_pkg::PROD_W'(len_q);
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[lri_pkg::PROD_W-2:0], qbit};
      rem_q <= qbit ? trial[lri_pkg::VAL_W-1:0] : rem_sh[lri_pkg::VAL_W-1:0];
    end
    if (cmd_i.load_out) begin
      out_q <= {6'b0, period_nz, finished_q, present_q};
    end
  end

  assign out_data_o = out_q;

endmodule

### hdl/lri_ctrl.sv
module lri_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  input  lri_pkg::dp_status_t status_i,
  output lri_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_EXEC  = 6'b000010,
    ST_MUL   = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_APPLY = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   m_valid_q, m_valid_d;
  logic   slot_free;

  assign slot_free = !m_valid_q || m_tready_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.execute = 1'b1;
        state_d       = status_i.tick_go ? ST_MUL : ST_EMIT;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_o.load_out) begin
      m_valid_d = 1'b1;
    end else if (m_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign m_tvalid_o = m_valid_q;

endmodule

### hdl/linear_ramp_interpolator_top.sv
// sequence: set and ramp commands and idle ticks pass from item accept through execute to emit;
//   a tick that moves the ramp runs setup, multiply, 64-step divide, apply and emit
// one item at a time: a new item is taken only once the last result is loaded; the bit-serial
//   divider by the stored period makes the moving tick the long case; emit waits on the output
// reset: asynchronous active low; value, goal and origin return to one in q16.16,
//   period and done to zero, direction to rising, both channels empty
module linear_ramp_interpolator_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input items
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // start_value [31:0], target_value [63:32], ramp_period [95:64], tick_length [127:96]
  input  logic [lri_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // cmd [1:0]
  input  logic [lri_pkg::CMD_W-1:0]          s_axis_tuser_i,
  // result items
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // current_value [31:0], done_res [32], period_valid [33], zero fill [39:34]
  output logic [lri_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o
);

  // command and status between the sequencer and the datapath
  lri_pkg::dp_cmd_t    dp_cmd;
  lri_pkg::dp_status_t dp_status;

  // sequencer: one item at a time; the result register lets a new item in
  // while the previous result still waits on the output side
  lri_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  // ramp state, step multiplier, restoring divider and result register
  lri_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .item_data_i (s_axis_tdata_i),
    .item_cmd_i  (s_axis_tuser_i),
    .out_data_o  (m_axis_tdata_o)
  );

`ifndef SYNTHESIS
  // once an item is taken the block is busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input accepted while previous item still in work");

  // a result is never written over one that has not been taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.load_out |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("pending result overwritten");

  // the divider only runs while the input side is closed
  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_cmd.div_step || dp_cmd.mul) |-> !s_axis_tready_o)
    else $error("divider stepping while input open");

  // the last divide step is always followed by the apply step
  a_div_then_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_cmd.div_step && dp_status.div_last) |=> dp_cmd.apply)
    else $error("divide end not followed by apply");
`endif

endmodule
